// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the Hamming stream encoder checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define H_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define H_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/h1511_pkg.sv =====
// ----------------------------------------------------------------------------
// h1511_pkg
// Request types, queue entry type and the (15,11) codeword builder.
// ----------------------------------------------------------------------------
package h1511_pkg;

    localparam int CW_BITS   = 15;
    localparam int DATA_BITS = 11;
    localparam int ACC_BITS  = 37;   // up to 7 leftover bits plus two codewords
    localparam int ACC_CNT_W = 6;

    typedef logic [3:0] t_pos;

    localparam t_pos DATA_POS [DATA_BITS] = '{
        4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0] coded_byte;
        logic       run_last;
        logic       stream_end;
    } t_out_req;

    // One classified input request: zero, one or two finished codewords.
    typedef struct packed {
        logic [CW_BITS-1:0] cw0;
        logic               cw0_vld;
        logic [CW_BITS-1:0] cw1;
        logic               cw1_vld;
        logic               last;
    } t_entry;

    // Position p of the codeword sits in bit 14-p.
    function automatic logic [CW_BITS-1:0] encode_word(input logic [DATA_BITS-1:0] d);
        logic [CW_BITS-1:0] w;
        logic               s;
        int                 i;
        int                 k;
        int                 q;
        int                 m;
        int                 p;
        w = '0;
        for (i = 0; i < DATA_BITS; i++) begin
            w[14 - int'(DATA_POS[i])] = d[10 - i];
        end
        for (k = 0; k < 4; k++) begin
            m = 1 << k;
            p = m - 1;
            s = 1'b0;
            for (q = 0; q < CW_BITS; q++) begin
                if (q != p && ((q + 1) & m) != 0) begin
                    s = s ^ w[14 - q];
                end
            end
            w[14 - p] = s;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/h1511_front.sv =====
// ----------------------------------------------------------------------------
// h1511_front
// Accepts raw bytes, gathers data bits and builds finished codewords.
// ----------------------------------------------------------------------------
module h1511_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  h1511_pkg::t_in_req i_in_data,
    input  logic               i_q_full,
    output logic               o_in_stall,
    output logic               o_push,
    output h1511_pkg::t_entry  o_entry
);
    import h1511_pkg::*;

    logic [DATA_BITS-1:0] r_data, n_data;
    logic [3:0]           r_cnt, n_cnt;

    logic [4:0]           total;
    logic [4:0]           sh;
    logic [18:0]          cat;
    logic [DATA_BITS-1:0] word_d;
    logic [DATA_BITS-1:0] data_a;
    logic [DATA_BITS-1:0] pad_d;
    logic [3:0]           cnt_a;
    logic                 full_word;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        total     = {1'b0, r_cnt} + 5'd8;
        cat       = {r_data, i_in_data.data_byte};
        full_word = (total >= 5'd11);
        sh        = total - 5'd11;
        word_d    = DATA_BITS'(cat >> sh);
        data_a    = cat[DATA_BITS-1:0];
        cnt_a     = full_word ? sh[3:0] : total[3:0];
        // pad the open codeword with zero data bits
        pad_d     = DATA_BITS'(data_a << (4'd11 - cnt_a));

        o_entry.cw0     = encode_word(word_d);
        o_entry.cw0_vld = full_word;
        o_entry.cw1     = encode_word(pad_d);
        o_entry.cw1_vld = i_in_data.last_byte && (cnt_a != 4'd0);
        o_entry.last    = i_in_data.last_byte;
    end

    always_comb begin
        n_data = r_data;
        n_cnt  = r_cnt;
        if (o_push) begin
            n_data = data_a;
            n_cnt  = i_in_data.last_byte ? 4'd0 : cnt_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
            r_cnt  <= '0;
        end else begin
            r_data <= n_data;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/h1511_queue.sv =====
// ----------------------------------------------------------------------------
// h1511_queue
// Small register queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module h1511_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  h1511_pkg::t_entry i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output h1511_pkg::t_entry o_head
);
    import h1511_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/core/h1511_back.sv =====
// ----------------------------------------------------------------------------
// h1511_back
// Packs codewords into a bit accumulator and sends one coded byte a cycle while not stalled.
// ----------------------------------------------------------------------------
module h1511_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  h1511_pkg::t_entry  i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output h1511_pkg::t_out_req o_out_data
);
    import h1511_pkg::*;

    logic [ACC_BITS-1:0]  r_acc, n_acc;
    logic [ACC_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_flush, n_flush;
    logic                 r_out_valid, n_out_valid;
    t_out_req             r_out, n_out;

    logic                 have_full;
    logic                 have_byte;
    logic                 load;
    logic                 emit;
    logic                 is_final;
    logic [ACC_CNT_W-1:0] rem;
    logic [ACC_CNT_W-1:0] c1;
    logic                 f1;
    logic                 drained;
    logic [7:0]           full_byte;
    logic [15:0]          tail_word;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        have_full = (r_cnt >= ACC_CNT_W'(8));
        have_byte = have_full || (r_flush && r_cnt != '0);
        load      = !r_out_valid || !i_out_stall;
        emit      = load && have_byte;
        rem       = have_full ? r_cnt - ACC_CNT_W'(8) : '0;
        is_final  = r_flush && (!have_full || rem == '0);
        full_byte = 8'(r_acc >> rem);
        tail_word = {r_acc[7:0], 8'h00} >> r_cnt[2:0];
        c1        = emit ? rem : r_cnt;
        f1        = (emit && is_final) ? 1'b0 : r_flush;
        drained   = (c1 < ACC_CNT_W'(8)) && !(f1 && c1 != '0);
        o_pop     = drained && !i_q_empty;
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (load) begin
            n_out_valid = have_byte;
        end
        if (emit) begin
            n_out.coded_byte = have_full ? full_byte : tail_word[7:0];
            n_out.run_last   = is_final || (!r_flush && rem < ACC_CNT_W'(8));
            n_out.stream_end = is_final;
        end
    end

    // accumulator: drop the sent byte, append the next request's codewords
    always_comb begin
        n_acc   = r_acc;
        n_cnt   = c1;
        n_flush = f1 && (c1 != '0);
        if (o_pop) begin
            n_flush = i_head.last;
            case ({i_head.cw0_vld, i_head.cw1_vld})
                2'b11: begin
                    n_acc = {r_acc[6:0], i_head.cw0, i_head.cw1};
                    n_cnt = c1 + ACC_CNT_W'(30);
                end
                2'b10: begin
                    n_acc = {r_acc[21:0], i_head.cw0};
                    n_cnt = c1 + ACC_CNT_W'(15);
                end
                2'b01: begin
                    n_acc = {r_acc[21:0], i_head.cw1};
                    n_cnt = c1 + ACC_CNT_W'(15);
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/hamming_15_11_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// hamming_15_11_stream_encoder
// Byte stream in, Hamming (15,11) coded byte stream out.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one raw byte
//   per request; set last_byte on the final byte of a stream. Output channel
//   (o_out_valid / i_out_stall / o_out_data) carries one coded byte per
//   request, with run_last on the last byte caused by an input request and
//   stream_end on the final byte of a stream.
//   Data bits fill the data positions of each codeword MSB first; codewords
//   leave MSB first. On last_byte the open codeword is zero padded and the
//   final output byte is padded with zero low bits.
//   A taken request passes the queue and the bit accumulator before its first
//   coded byte reaches the output register. A request yields 0 to 2 coded
//   bytes (a last_byte up to 5), sent one per cycle from the byte-wide output
//   register while i_out_stall is low; each 11 data bits become 15 coded bits.
//   The input side takes a request every cycle until the QUEUE_DEPTH-entry
//   queue fills; a stalled receiver fills the queue, then stalls the input.
//   Reset (synchronous, active low) empties the queue, drops partial data
//   and clears o_out_valid; the next byte starts a new stream.
// ----------------------------------------------------------------------------
module hamming_15_11_stream_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  h1511_pkg::t_in_req  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output h1511_pkg::t_out_req o_out_data
);
    import h1511_pkg::*;

    logic   q_full;
    logic   q_empty;
    logic   q_push;
    logic   q_pop;
    t_entry q_in;
    t_entry q_head;

    // front: gather data bits, close codewords, classify the request
    h1511_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    // queue: let the front run ahead while the back sends bytes
    h1511_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // back: serialize codewords into coded bytes, flush at stream end
    h1511_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/core/h1511_checker.sv =====
// ----------------------------------------------------------------------------
// h1511_checker
// Port-level checks for the Hamming stream encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module h1511_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input h1511_pkg::t_in_req  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input h1511_pkg::t_out_req o_out_data
);
    import h1511_pkg::*;

    // a held output request stays put
    `H_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "output request changed while stalled")

    // the end of a stream always closes the current request's run
    `H_ASSERT(a_end_run, i_clk, i_rst_n, o_out_valid && o_out_data.stream_end |-> o_out_data.run_last, "stream_end without run_last")

    // reset drops any pending output
    `H_ASSERT_ALWAYS(a_rst_clr, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind hamming_15_11_stream_encoder h1511_checker u_h1511_checker (.*);
